/* src/pfr_pkg.sv */
package pfr_pkg;

  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_GET_PIXEL = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_FILL      = 3'd3,
    OP_REFRESH   = 3'd4,
    OP_TICK      = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_SET,
    CMD_GET,
    CMD_GET_ZERO,
    CMD_CLEAR,
    CMD_FILL,
    CMD_REFRESH,
    CMD_TICK
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] bit_sel;
    logic       pixel_on;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MODIFY,
    BK_GET,
    BK_TICK,
    BK_SWEEP
  } back_state_e;

  typedef enum logic [1:0] {
    RF_PAGE,
    RF_COL_HI,
    RF_COL_LO,
    RF_DATA
  } rf_phase_e;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] LOW_NIBBLE    = 8'h0F;
  localparam logic [7:0] FILL_BYTE     = 8'hFF;
  localparam logic [7:0] CLEAR_BYTE    = 8'h00;
  localparam logic [7:0] BIT_ONE       = 8'h01;

  localparam logic REG_START_COLUMN = 1'b0;
  localparam logic REG_START_PAGE   = 1'b1;

endpackage

/* src/pfr_in_if.sv */
interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] pixel_x;
  logic [5:0] pixel_y;
  logic       pixel_on;

  modport source (output valid, output opcode, output pixel_x, output pixel_y,
                  output pixel_on, input ready);
  modport sink (input valid, input opcode, input pixel_x, input pixel_y,
                input pixel_on, output ready);
endinterface

/* src/pfr_out_if.sv */
interface pfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] result_value;
  logic       frame_last;

  modport source (output valid, output result_kind, output result_value,
                  output frame_last, input ready);
  modport sink (input valid, input result_kind, input result_value,
                input frame_last, output ready);
endinterface

/* src/pfr_front.sv */
module pfr_front #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int AW      = 10
) (
  pfr_in_if.sink        in_if,
  input  logic          init_busy_i,
  input  logic          push_ready_i,
  output logic          push_valid_o,
  output pfr_pkg::cmd_t push_cmd_o,
  output logic [AW-1:0] push_addr_o
);
  import pfr_pkg::*;

  localparam int CALCW = AW + 8;

  logic [2:0]       page;
  logic             in_store;
  logic             keep;
  logic [CALCW-1:0] addr_wide;

  assign page      = in_if.pixel_y[5:3];
  assign in_store  = (9'(in_if.pixel_x) < 9'(COLUMNS)) && (5'(page) < 5'(PAGES));
  assign addr_wide = CALCW'(page) * CALCW'(COLUMNS) + CALCW'(in_if.pixel_x);

  assign in_if.ready = push_ready_i && !init_busy_i;

  always_comb begin
    keep                = 1'b1;
    push_cmd_o.op       = CMD_TICK;
    push_cmd_o.bit_sel  = in_if.pixel_y[2:0];
    push_cmd_o.pixel_on = in_if.pixel_on;
    case (in_if.opcode)
      OP_SET_PIXEL: begin
        push_cmd_o.op = CMD_SET;
        keep          = in_store;
      end
      OP_GET_PIXEL: push_cmd_o.op = in_store ? CMD_GET : CMD_GET_ZERO;
      OP_CLEAR:     push_cmd_o.op = CMD_CLEAR;
      OP_FILL:      push_cmd_o.op = CMD_FILL;
      OP_REFRESH:   push_cmd_o.op = CMD_REFRESH;
      OP_TICK:      push_cmd_o.op = CMD_TICK;
      default:      keep = 1'b0;
    endcase
  end

  assign push_addr_o  = addr_wide[AW-1:0];
  assign push_valid_o = in_if.valid && in_if.ready && keep;

endmodule

/* src/pfr_queue.sv */
module pfr_queue #(
  parameter int DW    = 16,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/pfr_back.sv */
module pfr_back #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int AW      = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  pfr_pkg::cmd_t q_cmd_i,
  input  logic [AW-1:0] q_addr_i,
  output logic          q_pop_o,
  input  logic [6:0]    start_column_i,
  input  logic [2:0]    start_page_i,
  output logic          init_busy_o,
  pfr_out_if.source     out_if
);
  import pfr_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int CLW   = $clog2(COLUMNS);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;

  back_state_e    state_q, state_d;
  logic           init_q;

  logic [7:0]     mem [DEPTH];
  logic [7:0]     rdata_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  logic [7:0]     mem_wd;

  logic [AW-1:0]  cur_addr_q;
  logic [2:0]     cur_bit_q;
  logic           cur_on_q;
  logic [AW-1:0]  sweep_addr_q;
  logic [7:0]     sweep_val_q;
  logic           sweep_last;

  logic           rf_active_q;
  rf_phase_e      rf_phase_q;
  logic [PGW-1:0] rf_page_q;
  logic [CLW-1:0] rf_col_q;
  logic [AW-1:0]  rf_addr_q;
  logic           rf_last_col, rf_last_page;
  logic           rf_begin, rf_adv_cmd, rf_adv_data;
  logic [7:0]     rf_cmd_byte;

  logic           out_valid_q;
  logic           out_free;
  logic           emit;
  logic [1:0]     emit_kind;
  logic [7:0]     emit_value;
  logic           emit_last;
  logic           sweep_start;
  logic [7:0]     bit_mask;

  assign out_free     = !out_valid_q || out_if.ready;
  assign sweep_last   = (sweep_addr_q == AW'(DEPTH - 1));
  assign rf_last_col  = (rf_col_q == CLW'(COLUMNS - 1));
  assign rf_last_page = (rf_page_q == PGW'(PAGES - 1));
  assign bit_mask     = BIT_ONE << cur_bit_q;
  assign init_busy_o  = init_q;

  always_comb begin
    case (rf_phase_q)
      RF_PAGE:   rf_cmd_byte = CMD_PAGE_BASE + 8'(rf_page_q) + 8'(start_page_i);
      RF_COL_HI: rf_cmd_byte = CMD_COL_HIGH | {5'b0, start_column_i[6:4]};
      RF_COL_LO: rf_cmd_byte = LOW_NIBBLE & {4'b0, start_column_i[3:0]};
      default:   rf_cmd_byte = CLEAR_BYTE;
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    emit_kind   = KIND_PIXEL;
    emit_value  = CLEAR_BYTE;
    emit_last   = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = sweep_addr_q;
    mem_wd      = sweep_val_q;
    mem_re      = 1'b0;
    mem_ra      = q_addr_i;
    rf_begin    = 1'b0;
    rf_adv_cmd  = 1'b0;
    rf_adv_data = 1'b0;
    sweep_start = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            CMD_SET, CMD_GET: begin
              q_pop_o = 1'b1;
              mem_re  = 1'b1;
            end
            CMD_GET_ZERO: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                emit    = 1'b1;
              end
            end
            CMD_CLEAR, CMD_FILL: begin
              q_pop_o     = 1'b1;
              sweep_start = 1'b1;
              rf_begin    = 1'b1;
            end
            CMD_REFRESH: begin
              q_pop_o  = 1'b1;
              rf_begin = 1'b1;
            end
            CMD_TICK: begin
              if (!rf_active_q) begin
                q_pop_o = 1'b1;
              end else if (rf_phase_q == RF_DATA) begin
                q_pop_o = 1'b1;
                mem_re  = 1'b1;
                mem_ra  = rf_addr_q;
              end else if (out_free) begin
                q_pop_o    = 1'b1;
                emit       = 1'b1;
                emit_kind  = KIND_CMD;
                emit_value = rf_cmd_byte;
                rf_adv_cmd = 1'b1;
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      BK_MODIFY: begin
        mem_we = 1'b1;
        mem_wa = cur_addr_q;
        mem_wd = cur_on_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
      end
      BK_GET: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_value = {7'b0, rdata_q[cur_bit_q]};
        end
      end
      BK_TICK: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_kind   = KIND_DATA;
          emit_value  = rdata_q;
          emit_last   = rf_last_col && rf_last_page;
          rf_adv_data = 1'b1;
        end
      end
      BK_SWEEP: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          case (q_cmd_i.op)
            CMD_SET:             state_d = BK_MODIFY;
            CMD_GET:             state_d = BK_GET;
            CMD_CLEAR, CMD_FILL: state_d = BK_SWEEP;
            CMD_TICK:            state_d = mem_re ? BK_TICK : BK_IDLE;
            default:             state_d = BK_IDLE;
          endcase
        end
      end
      BK_MODIFY:        state_d = BK_IDLE;
      BK_GET, BK_TICK:  state_d = out_free ? BK_IDLE : state_q;
      BK_SWEEP:         state_d = sweep_last ? BK_IDLE : BK_SWEEP;
      default:          state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_SWEEP;
      init_q       <= 1'b1;
      sweep_addr_q <= '0;
      sweep_val_q  <= CLEAR_BYTE;
    end else begin
      state_q <= state_d;
      if (state_q == BK_SWEEP && sweep_last) begin
        init_q <= 1'b0;
      end
      if (sweep_start) begin
        sweep_addr_q <= '0;
        sweep_val_q  <= (q_cmd_i.op == CMD_FILL) ? FILL_BYTE : CLEAR_BYTE;
      end else if (state_q == BK_SWEEP) begin
        sweep_addr_q <= sweep_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_addr_q <= q_addr_i;
      cur_bit_q  <= q_cmd_i.bit_sel;
      cur_on_q   <= q_cmd_i.pixel_on;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_active_q <= 1'b0;
      rf_phase_q  <= RF_PAGE;
      rf_page_q   <= '0;
      rf_col_q    <= '0;
      rf_addr_q   <= '0;
    end else if (rf_begin) begin
      rf_active_q <= 1'b1;
      rf_phase_q  <= RF_PAGE;
      rf_page_q   <= '0;
      rf_col_q    <= '0;
      rf_addr_q   <= '0;
    end else if (rf_adv_cmd) begin
      case (rf_phase_q)
        RF_PAGE:   rf_phase_q <= RF_COL_HI;
        RF_COL_HI: rf_phase_q <= RF_COL_LO;
        default:   rf_phase_q <= RF_DATA;
      endcase
    end else if (rf_adv_data) begin
      rf_addr_q <= rf_addr_q + 1'b1;
      if (rf_last_col) begin
        rf_col_q   <= '0;
        rf_phase_q <= RF_PAGE;
        if (rf_last_page) begin
          rf_page_q   <= '0;
          rf_active_q <= 1'b0;
        end else begin
          rf_page_q <= rf_page_q + 1'b1;
        end
      end else begin
        rf_col_q <= rf_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_if.result_kind  <= emit_kind;
      out_if.result_value <= emit_value;
      out_if.frame_last   <= emit_last;
    end
  end

  assign out_if.valid = out_valid_q;

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result produced while the output register is still occupied");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("queue popped while empty");

  a_tick_while_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_TICK) |-> rf_active_q)
    else $error("data byte fetched with no refresh in progress");

  a_init_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (state_q == BK_SWEEP))
    else $error("initial clearing pass left before it finished");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_if.frame_last) |-> (out_if.result_kind == KIND_DATA))
    else $error("end-of-frame flag on a result that is not a data byte");

endmodule

/* src/page_framebuffer_refresh.sv */
// Page-mode monochrome frame store with a display refresh streamer. After reset the
// store is cleared by a pass over all PAGES*COLUMNS bytes, during which no transaction
// is accepted on the input channel. Requests enter a two-entry queue and are carried
// out in order by a back end built around a single-port store with a registered read:
// set pixel reads the byte, then writes it back; get pixel and a refresh data byte
// read the byte, then emit it; a refresh command byte, start refresh and a tick while
// idle need no store read, and clear or fill write one store byte per cycle.
// Ignored requests are dropped on entry and never reach the back end.
// Each result waits in an output register, so the back end goes on with requests that
// give no result, and the queue accepts until full, while a result is held back by the sink.
module page_framebuffer_refresh #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfr_in_if.sink      in_if,
  pfr_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfr_pkg::*;

  localparam int AW = $clog2(PAGES * COLUMNS);
  localparam int DW = $bits(cmd_t) + AW;

  logic [6:0]    start_column_q;
  logic [2:0]    start_page_q;
  logic          cfg_write;

  logic          init_busy;
  logic          push_valid, push_ready;
  cmd_t          push_cmd;
  logic [AW-1:0] push_addr;
  logic          pop_valid, pop;
  logic [DW-1:0] pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_column_q <= '0;
      start_page_q   <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_START_COLUMN: start_column_q <= pwdata[6:0];
        REG_START_PAGE:   start_page_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_COLUMN: prdata = {25'b0, start_column_q};
      REG_START_PAGE:   prdata = {29'b0, start_page_q};
      default:          prdata = '0;
    endcase
  end

  pfr_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES),
    .AW     (AW)
  ) u_front (
    .in_if       (in_if),
    .init_busy_i (init_busy),
    .push_ready_i(push_ready),
    .push_valid_o(push_valid),
    .push_cmd_o  (push_cmd),
    .push_addr_o (push_addr)
  );

  pfr_queue #(
    .DW   (DW),
    .DEPTH(2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_cmd, push_addr}),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  pfr_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES),
    .AW     (AW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (pop_valid),
    .q_cmd_i       (cmd_t'(pop_data[DW-1:AW])),
    .q_addr_i      (pop_data[AW-1:0]),
    .q_pop_o       (pop),
    .start_column_i(start_column_q),
    .start_page_i  (start_page_q),
    .init_busy_o   (init_busy),
    .out_if        (out_if)
  );

endmodule

/* test/tb.sv */
module tb;
  import pfr_pkg::*;

  localparam int COLS = 128;
  localparam int PGS = 8;
  localparam int DRAIN_CYCLES = 4 * (PGS * COLS + 1) + 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_AFTER = 500;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] x;
    logic [5:0] y;
    logic       on;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    request_t     rq;
    logic         typed;
    stream_byte_t want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pfr_in_if in_ch ();
  pfr_out_if out_ch ();

  page_framebuffer_refresh #(
    .COLUMNS(COLS),
    .PAGES(PGS)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic [7:0] frame_bytes [PGS*COLS];
  logic scan_on;
  int scan_page;
  int scan_pos;
  logic [6:0] col_offset;
  logic [2:0] page_offset;

  stream_byte_t pending_out[$];
  script_row_t script[$];
  int errors;
  int sent_count;
  int seen_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void clear_model(logic [7:0] fill);
    foreach (frame_bytes[i]) frame_bytes[i] = fill;
    scan_on = 1'b1;
    scan_page = 0;
    scan_pos = 0;
  endfunction

  function automatic logic scan_tick(output stream_byte_t sb);
    int c;
    sb = '0;
    if (!scan_on) return 1'b0;
    case (scan_pos)
      0: begin
        sb.kind = KIND_CMD;
        sb.value = CMD_PAGE_BASE + 8'(scan_page) + {5'b0, page_offset};
        scan_pos = 1;
      end
      1: begin
        sb.kind = KIND_CMD;
        sb.value = CMD_COL_HIGH | {5'b0, col_offset[6:4]};
        scan_pos = 2;
      end
      2: begin
        sb.kind = KIND_CMD;
        sb.value = {1'b0, col_offset} & LOW_NIBBLE;
        scan_pos = 3;
      end
      default: begin
        c = scan_pos - 3;
        sb.kind = KIND_DATA;
        sb.value = frame_bytes[scan_page*COLS + c];
        if (c == COLS - 1) begin
          scan_pos = 0;
          if (scan_page == PGS - 1) begin
            scan_page = 0;
            scan_on = 1'b0;
            sb.last = 1'b1;
          end else begin
            scan_page++;
          end
        end else begin
          scan_pos++;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic logic step_model(request_t rq, output stream_byte_t sb);
    int idx;
    idx = int'(rq.y[5:3]) * COLS + int'(rq.x);
    sb = '0;
    case (rq.opcode)
      OP_SET_PIXEL: begin
        frame_bytes[idx][rq.y[2:0]] = rq.on;
        return 1'b0;
      end
      OP_GET_PIXEL: begin
        sb.kind = KIND_PIXEL;
        sb.value = {7'b0, frame_bytes[idx][rq.y[2:0]]};
        return 1'b1;
      end
      OP_CLEAR: clear_model(CLEAR_BYTE);
      OP_FILL: clear_model(FILL_BYTE);
      OP_REFRESH: begin
        scan_on = 1'b1;
        scan_page = 0;
        scan_pos = 0;
      end
      OP_TICK: return scan_tick(sb);
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic request_t draw_request(int tick_pct, int restart_pct);
    request_t rq;
    int r;
    int k;
    rq.x = 7'($urandom_range(0, 127));
    rq.y = 6'($urandom_range(0, 63));
    rq.on = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      rq.opcode = OP_TICK;
    end else if (r < tick_pct + restart_pct) begin
      k = $urandom_range(0, 2);
      rq.opcode = (k == 0) ? OP_REFRESH : (k == 1) ? OP_CLEAR : OP_FILL;
    end else begin
      k = $urandom_range(0, 9);
      if (k < 6) rq.opcode = OP_SET_PIXEL;
      else if (k < 9) rq.opcode = OP_GET_PIXEL;
      else rq.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end
    return rq;
  endfunction

  task automatic push(request_t rq, logic typed, stream_byte_t want);
    stream_byte_t sb;
    logic got;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= rq.opcode;
    in_ch.pixel_x <= rq.x;
    in_ch.pixel_y <= rq.y;
    in_ch.pixel_on <= rq.on;
    do @(posedge clk); while (!in_ch.ready);
    got = step_model(rq, sb);
    if (typed) pending_out.push_back(want);
    else if (got) pending_out.push_back(sb);
    sent_count++;
    gap = pick_gap(((sent_count / 128) % 4 == 0) ? 0 : 25);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    paddr <= {idx, 2'b00};
    pwdata <= v;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_START_COLUMN) col_offset = v[6:0];
    else page_offset = v[2:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) begin
      $display("%0t: register %0d read expected %0h got %0h", $time, idx, v, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(logic [2:0] op, logic [6:0] x, logic [5:0] y, logic on,
                         logic typed, logic [1:0] kind, logic [7:0] value);
    script_row_t row;
    row.rq = '{opcode: op, x: x, y: y, on: on};
    row.typed = typed;
    row.want = '{kind: kind, value: value, last: 1'b0};
    script.push_back(row);
  endtask

  task automatic run_phase(logic [6:0] col, logic [2:0] pg, logic [2:0] first_op,
                           int count, int tick_pct, int restart_pct);
    request_t rq;
    settle();
    reg_write(REG_START_COLUMN, {25'b0, col});
    reg_write(REG_START_PAGE, {29'b0, pg});
    rq = draw_request(0, 0);
    rq.opcode = first_op;
    push(rq, 1'b0, '0);
    repeat (count) push(draw_request(tick_pct, restart_pct), 1'b0, '0);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("page_framebuffer_refresh verification failed");
    $finish;
  end

  initial begin
    int stall_left;
    logic held;
    stream_byte_t exp_b;
    stall_left = 0;
    held = 1'b0;
    seen_count = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        seen_count++;
        if (pending_out.size() == 0) begin
          $display("%0t: unexpected transaction kind %0d value %0h last %0b", $time,
                   out_ch.result_kind, out_ch.result_value, out_ch.frame_last);
          errors++;
        end else begin
          exp_b = pending_out.pop_front();
          if (out_ch.result_kind !== exp_b.kind) begin
            $display("%0t: result_kind expected %0d got %0d", $time, exp_b.kind,
                     out_ch.result_kind);
            errors++;
          end
          if (out_ch.result_value !== exp_b.value) begin
            $display("%0t: result_value expected %0h got %0h", $time, exp_b.value,
                     out_ch.result_value);
            errors++;
          end
          if (out_ch.frame_last !== exp_b.last) begin
            $display("%0t: frame_last expected %0b got %0b", $time, exp_b.last,
                     out_ch.frame_last);
            errors++;
          end
        end
      end
      if (!held && seen_count >= HOLD_AFTER) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && (seen_count / 128) % 4 != 0) stall_left = pick_gap(25);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    sent_count = 0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_TICK;
    in_ch.pixel_x <= '0;
    in_ch.pixel_y <= '0;
    in_ch.pixel_on <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    foreach (frame_bytes[i]) frame_bytes[i] = CLEAR_BYTE;
    scan_on = 1'b0;
    scan_page = 0;
    scan_pos = 0;
    col_offset = '0;
    page_offset = '0;

    add_row(OP_GET_PIXEL, 7'd0, 6'd0, 1'b0, 1'b1, KIND_PIXEL, CLEAR_BYTE);
    add_row(OP_GET_PIXEL, 7'd127, 6'd63, 1'b1, 1'b1, KIND_PIXEL, CLEAR_BYTE);
    add_row(OP_TICK, 7'd5, 6'd5, 1'b0, 1'b0, '0, '0);
    add_row(OP_SET_PIXEL, 7'd0, 6'd0, 1'b1, 1'b0, '0, '0);
    add_row(OP_SET_PIXEL, 7'd127, 6'd63, 1'b1, 1'b0, '0, '0);
    add_row(OP_GET_PIXEL, 7'd0, 6'd0, 1'b0, 1'b1, KIND_PIXEL, BIT_ONE);
    add_row(OP_GET_PIXEL, 7'd127, 6'd63, 1'b0, 1'b1, KIND_PIXEL, BIT_ONE);
    add_row(OP_SET_PIXEL, 7'd127, 6'd63, 1'b0, 1'b0, '0, '0);
    add_row(OP_GET_PIXEL, 7'd127, 6'd63, 1'b1, 1'b1, KIND_PIXEL, CLEAR_BYTE);
    add_row(OP_REFRESH, 7'd64, 6'd32, 1'b1, 1'b0, '0, '0);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b1, KIND_CMD, CMD_PAGE_BASE);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b1, KIND_CMD, CMD_COL_HIGH);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b0, '0, '0);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b0, '0, '0);
    add_row(OP_SET_PIXEL, 7'd1, 6'd0, 1'b1, 1'b0, '0, '0);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b0, '0, '0);
    add_row(OP_REFRESH, 7'd0, 6'd0, 1'b0, 1'b0, '0, '0);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b1, KIND_CMD, CMD_PAGE_BASE);
    add_row(OP_FILL, 7'd0, 6'd0, 1'b0, 1'b0, '0, '0);
    add_row(OP_GET_PIXEL, 7'd64, 6'd31, 1'b0, 1'b1, KIND_PIXEL, BIT_ONE);
    add_row(OP_TICK, 7'd0, 6'd0, 1'b0, 1'b1, KIND_CMD, CMD_PAGE_BASE);
    add_row(OP_CLEAR, 7'd127, 6'd63, 1'b1, 1'b0, '0, '0);
    add_row(OP_GET_PIXEL, 7'd5, 6'd9, 1'b0, 1'b1, KIND_PIXEL, CLEAR_BYTE);
    add_row(OP_SPARE_LO, 7'd127, 6'd63, 1'b1, 1'b0, '0, '0);
    add_row(OP_SPARE_HI, 7'd42, 6'd21, 1'b0, 1'b0, '0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle();
    reg_write(REG_START_COLUMN, 32'd0);
    reg_write(REG_START_PAGE, 32'd0);
    foreach (script[i]) push(script[i].rq, script[i].typed, script[i].want);

    run_phase(7'd127, 3'd7, OP_FILL, 1250, 90, 0);
    run_phase(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)), OP_REFRESH,
              200, 60, 3);
    run_phase(7'd0, 3'd7, OP_CLEAR, 200, 45, 5);
    settle();

    if (errors == 0) begin
      $display("page_framebuffer_refresh verification clean");
    end else begin
      $display("page_framebuffer_refresh verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pfr_pkg.sv
src/pfr_in_if.sv
src/pfr_out_if.sv
src/pfr_front.sv
src/pfr_queue.sv
src/pfr_back.sv
src/page_framebuffer_refresh.sv
test/tb.sv
